/* sv/scalar_kalman_fixed_point_top_assert.svh */
// Assertion macros for the scalar Kalman filter block
`ifndef SCALAR_KALMAN_FIXED_POINT_TOP_ASSERT_SVH
`define SCALAR_KALMAN_FIXED_POINT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define SKF_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("skf assertion failed");
// next-cycle implication
`define SKF_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("skf assertion failed");
`else
`define SKF_ASSERT_NOW(label, pre, post)
`define SKF_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* sv/skf_pkg.sv */
// Shared types and constants of the scalar Kalman filter
`default_nettype none

package skf_pkg;

	localparam int EST_OUT_W      = 32;
	localparam int GAIN_W         = 17;
	localparam int INIT_W         = 32;
	localparam int NOISE_W        = 16;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int COV_CAP_W      = 48;
	localparam int WORD_LIMIT_W   = 64;

	localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = 16'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INIT_EST   = 2'd0,
		CFG_PROC_NOISE = 2'd1,
		CFG_MEAS_NOISE = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED,
		ST_DEN,
		ST_DIV,
		ST_DIFF,
		ST_MULE,
		ST_UPDE,
		ST_MULC,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

/* sv/skf_if.sv */
// Measurement and result channel interfaces
`default_nettype none

interface skf_meas_if #(
	parameter int MEAS_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [MEAS_WIDTH-1:0] measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface

interface skf_res_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [skf_pkg::EST_OUT_W-1:0]   estimate;
	logic        [skf_pkg::GAIN_W-1:0]      gain;

	modport source (output valid, output estimate, output gain, input ready);
	modport sink (input valid, input estimate, input gain, output ready);
endinterface

`default_nettype wire

/* sv/scalar_kalman_fixed_point_top.sv */
// Scalar Kalman filter, fixed point, one shared adder under a sequencer.
// A measurement is accepted only in idle; the block takes no new one until it is back in idle.
// Each item runs the three FRAC_BITS+1 step loops (gain divide, estimate and covariance
// multiplies) on the adder, and finish waits while an earlier result is still not taken.
// Reset (arst_n low, asynchronous): estimate 0, covariance one, process noise 0,
// measurement noise 1; a config write sets the estimate to the initial value, covariance to one.
`default_nettype none
`include "scalar_kalman_fixed_point_top_assert.svh"

module scalar_kalman_fixed_point_top #(
	parameter int FRAC_BITS  = 16,
	parameter int MEAS_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [skf_pkg::CFG_DATA_W-1:0]    cfg_data,
	skf_meas_if.sink                               meas,
	skf_res_if.source                              result
);

	localparam int EST_W = skf_pkg::INIT_W + FRAC_BITS;
	localparam int COV_W = (skf_pkg::WORD_LIMIT_W - FRAC_BITS < skf_pkg::COV_CAP_W) ?
		skf_pkg::WORD_LIMIT_W - FRAC_BITS : skf_pkg::COV_CAP_W;
	localparam int DEN_W = COV_W + 1;
	localparam int MC_W  = (EST_W + 1 > COV_W) ? EST_W + 1 : COV_W;
	localparam int ACC_W = MC_W + FRAC_BITS + 1;
	localparam int U_W   = ACC_W + 1;
	localparam int G_W   = FRAC_BITS + 1;
	localparam int CNT_W = $clog2(G_W);

	localparam logic [G_W-1:0]   ONE_G    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [COV_W-1:0] COV_ONE  = COV_W'(ONE_G);
	localparam logic [COV_W-1:0] COV_MAX  = '1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

	skf_pkg::state_t state_q, state_d;

	// config registers and filter state
	logic signed [skf_pkg::INIT_W-1:0]  init_q;
	logic        [skf_pkg::NOISE_W-1:0] qn_q;
	logic        [skf_pkg::NOISE_W-1:0] rn_q;
	logic signed [EST_W-1:0]            est_q;
	logic        [COV_W-1:0]            cov_q;
	logic        [G_W-1:0]              gain_q;
	logic        [CNT_W-1:0]            cnt_q;
	logic                               out_valid_q;

	// working registers
	logic signed [MEAS_WIDTH-1:0]          meas_q;
	logic        [DEN_W-1:0]               den_q;
	logic                                  den_zero_q;
	logic        [ACC_W-1:0]               acc_q;
	logic signed [EST_W:0]                 diff_q;
	logic signed [skf_pkg::EST_OUT_W-1:0]  est_out_q;
	logic        [skf_pkg::GAIN_W-1:0]     gain_out_q;

	// shared adder
	logic [U_W-1:0] alu_a, alu_b, alu_sum;
	logic           alu_sub;
	logic           alu_neg;

	logic signed [skf_pkg::INIT_W-1:0] meas_ext;
	logic signed [EST_W-1:0]           meas_fix;
	logic        [G_W-1:0]             ginv;
	logic        [ACC_W-1:0]           acc_shl;
	logic        [ACC_W-1:0]           rem_new;
	logic        [COV_W-1:0]           cov_sat;
	logic                              round_up;
	logic                              fin_go;
	logic                              cfg_hit;
	logic signed [skf_pkg::INIT_W-1:0] init_new;

	assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + U_W'(alu_sub);
	assign alu_neg  = alu_sum[U_W-1];

	assign meas_ext = skf_pkg::INIT_W'(meas_q);
	assign meas_fix = {meas_ext, {FRAC_BITS{1'b0}}};
	assign ginv     = ONE_G - gain_q;
	assign acc_shl  = {acc_q[ACC_W-2:0], 1'b0};
	// restoring divide: keep the trial difference only when it did not go negative
	assign rem_new  = alu_neg ? acc_q : alu_sum[ACC_W-1:0];
	assign cov_sat  = (alu_sum > U_W'(COV_MAX)) ? COV_MAX : alu_sum[COV_W-1:0];
	// floor to truncate-toward-zero correction for the integer estimate
	assign round_up = est_q[EST_W-1] && (est_q[FRAC_BITS-1:0] != '0);
	assign fin_go   = !out_valid_q || result.ready;

	assign cfg_hit  = cfg_wr_en && (cfg_index == skf_pkg::CFG_INIT_EST ||
		cfg_index == skf_pkg::CFG_PROC_NOISE || cfg_index == skf_pkg::CFG_MEAS_NOISE);
	assign init_new = (cfg_index == skf_pkg::CFG_INIT_EST) ?
		skf_pkg::INIT_W'(cfg_data) : init_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			skf_pkg::ST_IDLE: begin
				if (meas.valid) state_d = skf_pkg::ST_PRED;
			end
			skf_pkg::ST_PRED: state_d = skf_pkg::ST_DEN;
			skf_pkg::ST_DEN:  state_d = skf_pkg::ST_DIV;
			skf_pkg::ST_DIV: begin
				if (cnt_q == '0) state_d = skf_pkg::ST_DIFF;
			end
			skf_pkg::ST_DIFF: state_d = skf_pkg::ST_MULE;
			skf_pkg::ST_MULE: begin
				if (cnt_q == '0) state_d = skf_pkg::ST_UPDE;
			end
			skf_pkg::ST_UPDE: state_d = skf_pkg::ST_MULC;
			skf_pkg::ST_MULC: begin
				if (cnt_q == '0) state_d = skf_pkg::ST_FIN;
			end
			skf_pkg::ST_FIN: begin
				if (fin_go) state_d = skf_pkg::ST_IDLE;
			end
			default: state_d = skf_pkg::ST_IDLE;
		endcase
	end

	// adder operands and handshake
	always_comb begin
		alu_a      = '0;
		alu_b      = '0;
		alu_sub    = 1'b0;
		meas.ready = 1'b0;
		case (state_q)
			skf_pkg::ST_IDLE: meas.ready = 1'b1;
			skf_pkg::ST_PRED: begin
				alu_a = U_W'(cov_q);
				alu_b = U_W'(qn_q) << FRAC_BITS;
			end
			skf_pkg::ST_DEN: begin
				alu_a = U_W'(cov_q);
				alu_b = U_W'(rn_q) << FRAC_BITS;
			end
			skf_pkg::ST_DIV: begin
				alu_a   = U_W'(acc_q);
				alu_b   = U_W'(den_q);
				alu_sub = 1'b1;
			end
			skf_pkg::ST_DIFF: begin
				alu_a   = U_W'(meas_fix);
				alu_b   = U_W'(est_q);
				alu_sub = 1'b1;
			end
			skf_pkg::ST_MULE: begin
				// MSB-first shift-add, signed multiplicand
				alu_a = U_W'(acc_shl);
				alu_b = gain_q[cnt_q] ? U_W'(diff_q) : '0;
			end
			skf_pkg::ST_UPDE: begin
				alu_a = U_W'(est_q);
				alu_b = U_W'($signed(acc_q) >>> FRAC_BITS);
			end
			skf_pkg::ST_MULC: begin
				alu_a = U_W'(acc_shl);
				alu_b = ginv[cnt_q] ? U_W'(cov_q) : '0;
			end
			skf_pkg::ST_FIN: begin
				alu_a = U_W'(est_q >>> FRAC_BITS);
				alu_b = U_W'(round_up);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '0;
			qn_q        <= '0;
			rn_q        <= skf_pkg::MEAS_NOISE_RST;
			est_q       <= '0;
			cov_q       <= COV_ONE;
			gain_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) out_valid_q <= 1'b0;
			if (cfg_hit) begin
				case (cfg_index)
					skf_pkg::CFG_INIT_EST:   init_q <= skf_pkg::INIT_W'(cfg_data);
					skf_pkg::CFG_PROC_NOISE: qn_q <= skf_pkg::NOISE_W'(cfg_data);
					skf_pkg::CFG_MEAS_NOISE: rn_q <= skf_pkg::NOISE_W'(cfg_data);
					default: ;
				endcase
				est_q  <= {init_new, {FRAC_BITS{1'b0}}};
				cov_q  <= COV_ONE;
				gain_q <= '0;
			end else begin
				case (state_q)
					skf_pkg::ST_PRED: cov_q <= cov_sat;
					skf_pkg::ST_DEN:  cnt_q <= CNT_LAST;
					skf_pkg::ST_DIV: begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == '0 && den_zero_q) gain_q <= '0;
						else gain_q <= {gain_q[G_W-2:0], !alu_neg};
					end
					skf_pkg::ST_DIFF: cnt_q <= CNT_LAST;
					skf_pkg::ST_MULE: cnt_q <= cnt_q - CNT_W'(1);
					skf_pkg::ST_UPDE: begin
						est_q <= alu_sum[EST_W-1:0];
						cnt_q <= CNT_LAST;
					end
					skf_pkg::ST_MULC: cnt_q <= cnt_q - CNT_W'(1);
					skf_pkg::ST_FIN: begin
						if (fin_go) begin
							cov_q       <= acc_q[FRAC_BITS +: COV_W];
							out_valid_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (meas.valid && meas.ready) meas_q <= meas.measurement;
		case (state_q)
			skf_pkg::ST_DEN: begin
				den_q      <= alu_sum[DEN_W-1:0];
				den_zero_q <= (alu_sum == '0);
				acc_q      <= ACC_W'(cov_q);
			end
			skf_pkg::ST_DIV:  acc_q <= {rem_new[ACC_W-2:0], 1'b0};
			skf_pkg::ST_DIFF: begin
				diff_q <= alu_sum[EST_W:0];
				acc_q  <= '0;
			end
			skf_pkg::ST_MULE: acc_q <= alu_sum[ACC_W-1:0];
			skf_pkg::ST_UPDE: acc_q <= '0;
			skf_pkg::ST_MULC: acc_q <= alu_sum[ACC_W-1:0];
			skf_pkg::ST_FIN: begin
				if (fin_go) begin
					est_out_q  <= alu_sum[skf_pkg::EST_OUT_W-1:0];
					gain_out_q <= skf_pkg::GAIN_W'(gain_q);
				end
			end
			default: ;
		endcase
	end

	assign result.valid    = out_valid_q;
	assign result.estimate = est_out_q;
	assign result.gain     = gain_out_q;

	`SKF_ASSERT_NEXT(a_accept_starts, meas.valid && meas.ready, state_q == skf_pkg::ST_PRED)
	`SKF_ASSERT_NOW(a_gain_le_one, state_q == skf_pkg::ST_DIFF, gain_q <= ONE_G)
	`SKF_ASSERT_NOW(a_zero_den_gain, state_q == skf_pkg::ST_DIFF && den_zero_q, gain_q == '0)
	`SKF_ASSERT_NOW(a_cnt_range, state_q == skf_pkg::ST_DIV, cnt_q <= CNT_LAST)
	`SKF_ASSERT_NEXT(a_fin_result, state_q == skf_pkg::ST_FIN && fin_go, out_valid_q)

endmodule

`default_nettype wire
